// ----- hdl/tpd_pkg.sv -----
// shared types, constants and helpers for the planar tile palette decoder
package tpd_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);
    localparam int TILE_PAIRS  = 32;
    localparam int CNT_W       = $clog2(TILE_PAIRS);
    localparam int ROWS        = 8;
    localparam int ROW_W       = $clog2(ROWS);

    localparam logic ACT_PAL_WRITE = 1'b0;
    localparam logic ACT_TILE      = 1'b1;
    localparam logic DEPTH_4BPP    = 1'b1;

    typedef struct packed {
        logic       vld;
        logic       last;
        logic       zero0;
        logic       zero1;
        logic [7:0] addr0;
        logic [7:0] addr1;
    } issue_t;

    typedef struct packed {
        logic busy;
        logic at_last;
    } gen_status_t;

    // palette index of one pixel from its four plane bytes
    function automatic logic [3:0] pix_index(
        input logic [7:0] p0,
        input logic [7:0] p1,
        input logic [7:0] p2,
        input logic [7:0] p3,
        input logic [2:0] b,
        input logic       deep
    );
        logic [3:0] idx;
        idx = {p3[b] & deep, p2[b] & deep, p1[b], p0[b]};
        return idx;
    endfunction

    // palette address for a sub-palette and pixel index
    function automatic logic [7:0] pal_addr_of(
        input logic [3:0] sub,
        input logic [3:0] idx,
        input logic       deep
    );
        logic [7:0] a;
        a = (deep == DEPTH_4BPP) ? {sub, idx} : {2'b00, sub, idx[1:0]};
        return a;
    endfunction

endpackage

// ----- hdl/planar_tile_palette_decoder.sv -----
// top level of the planar tile palette decoder
//
//   channel  dir  handshake           payload
//   s_       in   s_valid / s_ready   action, palette write fields, tile fields
//   m_       out  m_valid / m_ready   pixel_pair, last_pair
//
// a tile issues one pair per cycle unless the output stalls, 32 pairs per item; the pair rate is
// set by the two read ports of the palette memory
// pairs pass the palette read and output registers; next item taken on the last issue
// reset clears the palette valid bits, so every entry reads zero until written
// output stall freezes the read pipeline; palette writes are still taken when no tile issues
module planar_tile_palette_decoder
    import tpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_pal_addr,
    input  logic [15:0] s_pal_color,
    input  logic        s_tile_depth,
    input  logic [3:0]  s_sub_palette,
    input  logic [63:0] s_rows_low_half,
    input  logic [63:0] s_rows_high_half,
    input  logic [63:0] s_upper_planes_low,
    input  logic [63:0] s_upper_planes_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_pair,
    output logic        m_last_pair
);

    issue_t      issue;
    gen_status_t st;

    logic        en;
    logic        take;
    logic [15:0] rd0;
    logic [15:0] rd1;

    logic        p1_vld_reg;
    logic        p1_last_reg;
    logic        p1_z0_reg;
    logic        p1_z1_reg;
    logic        m_valid_reg;
    logic        m_last_reg;
    logic [31:0] m_pair_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = !st.busy || (st.at_last && en);
    assign take    = s_valid && s_ready;

    tpd_addr_gen u_gen (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .load              (take && (s_action == ACT_TILE)),
        .adv               (en),
        .tile_depth        (s_tile_depth),
        .sub_palette       (s_sub_palette),
        .rows_low_half     (s_rows_low_half),
        .rows_high_half    (s_rows_high_half),
        .upper_planes_low  (s_upper_planes_low),
        .upper_planes_high (s_upper_planes_high),
        .issue             (issue),
        .status            (st)
    );

    tpd_pal_ram u_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (take && (s_action == ACT_PAL_WRITE)),
        .wr_addr  (s_pal_addr),
        .wr_data  (s_pal_color),
        .rd_en    (en),
        .rd_addr0 (issue.addr0),
        .rd_addr1 (issue.addr1),
        .rd_data0 (rd0),
        .rd_data1 (rd1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg  <= issue.vld;
            m_valid_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_last_reg <= issue.last;
            p1_z0_reg   <= issue.zero0;
            p1_z1_reg   <= issue.zero1;
            m_last_reg  <= p1_last_reg;
            m_pair_reg  <= {p1_z1_reg ? 16'h0000 : rd1, p1_z0_reg ? 16'h0000 : rd0};
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_pair = m_pair_reg;
    assign m_last_pair  = m_last_reg;

    a_burst_end: assert property (@(posedge aclk) disable iff (!aresetn)
        st.busy && st.at_last && en && !(take && s_action == ACT_TILE) |=> !st.busy)
        else $error("tile issue did not stop after the last pair");

    a_tile_start: assert property (@(posedge aclk) disable iff (!aresetn)
        take && s_action == ACT_TILE |=> st.busy && !st.at_last)
        else $error("tile item did not start a fresh pair sequence");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_vld_reg && !en |=> p1_vld_reg && $stable(p1_last_reg))
        else $error("read stage lost an item during an output stall");

endmodule

// ----- hdl/tpd_pal_ram.sv -----
// palette memory: one write port, two registered read ports, reset to zero via valid bits
module tpd_pal_ram
    import tpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  logic [7:0]  wr_addr,
    input  logic [15:0] wr_data,
    input  logic        rd_en,
    input  logic [7:0]  rd_addr0,
    input  logic [7:0]  rd_addr1,
    output logic [15:0] rd_data0,
    output logic [15:0] rd_data1
);

    logic [15:0]            pal_mem [PAL_ENTRIES];
    logic [PAL_ENTRIES-1:0] vld_reg;
    logic [15:0]            rd0_reg;
    logic [15:0]            rd1_reg;

    logic             wr_ok;
    logic             rd0_ok;
    logic             rd1_ok;
    logic [PAL_AW-1:0] wr_idx;
    logic [PAL_AW-1:0] rd0_idx;
    logic [PAL_AW-1:0] rd1_idx;

    assign wr_ok   = wr_en && ({1'b0, wr_addr} < 9'(PAL_ENTRIES));
    assign rd0_ok  = {1'b0, rd_addr0} < 9'(PAL_ENTRIES);
    assign rd1_ok  = {1'b0, rd_addr1} < 9'(PAL_ENTRIES);
    assign wr_idx  = wr_addr[PAL_AW-1:0];
    assign rd0_idx = rd_addr0[PAL_AW-1:0];
    assign rd1_idx = rd_addr1[PAL_AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_ok) begin
            vld_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            pal_mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd0_reg <= (rd0_ok && vld_reg[rd0_idx]) ? pal_mem[rd0_idx] : 16'h0000;
            rd1_reg <= (rd1_ok && vld_reg[rd1_idx]) ? pal_mem[rd1_idx] : 16'h0000;
        end
    end

    assign rd_data0 = rd0_reg;
    assign rd_data1 = rd1_reg;

endmodule

// ----- hdl/tpd_addr_gen.sv -----
// tile register and pair sequencer producing two palette reads per cycle while adv is high
module tpd_addr_gen
    import tpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  logic        adv,
    input  logic        tile_depth,
    input  logic [3:0]  sub_palette,
    input  logic [63:0] rows_low_half,
    input  logic [63:0] rows_high_half,
    input  logic [63:0] upper_planes_low,
    input  logic [63:0] upper_planes_high,
    output issue_t      issue,
    output gen_status_t status
);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             deep_reg;
    logic [3:0]       sub_reg;
    logic [15:0]      lo_reg [ROWS];
    logic [15:0]      hi_reg [ROWS];

    logic             at_last;
    logic [ROW_W-1:0] row;
    logic [2:0]       b0;
    logic [2:0]       b1;
    logic [15:0]      w;
    logic [15:0]      u;
    logic [3:0]       idx0;
    logic [3:0]       idx1;

    assign at_last = cnt_reg == CNT_W'(TILE_PAIRS - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg && adv) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (at_last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            deep_reg <= tile_depth;
            sub_reg  <= sub_palette;
            for (int i = 0; i < 4; i++) begin
                lo_reg[i]     <= rows_low_half[16*i +: 16];
                lo_reg[i + 4] <= rows_high_half[16*i +: 16];
                hi_reg[i]     <= upper_planes_low[16*i +: 16];
                hi_reg[i + 4] <= upper_planes_high[16*i +: 16];
            end
        end
    end

    // rows 7..4 then 3..0, pair order within each four-row group
    assign row = {~cnt_reg[4], ~cnt_reg[2], ~cnt_reg[0]};
    assign b0  = {~cnt_reg[3], ~cnt_reg[1], 1'b1};
    assign b1  = {~cnt_reg[3], ~cnt_reg[1], 1'b0};
    assign w   = lo_reg[row];
    assign u   = hi_reg[row];

    assign idx0 = pix_index(w[7:0], w[15:8], u[7:0], u[15:8], b0, deep_reg);
    assign idx1 = pix_index(w[7:0], w[15:8], u[7:0], u[15:8], b1, deep_reg);

    always_comb begin
        issue.vld   = busy_reg;
        issue.last  = at_last;
        issue.zero0 = idx0 == 4'd0;
        issue.zero1 = idx1 == 4'd0;
        issue.addr0 = pal_addr_of(sub_reg, idx0, deep_reg);
        issue.addr1 = pal_addr_of(sub_reg, idx1, deep_reg);
    end

    assign status.busy    = busy_reg;
    assign status.at_last = at_last;

endmodule

// ----- sim/tb_planar_tile_palette_decoder.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the planar tile palette decoder: directed and random palette writes and tiles
module tb_planar_tile_palette_decoder;
    import tpd_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int RANDOM_ITEMS = 78;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic        action;
        logic [7:0]  pal_addr;
        logic [15:0] pal_color;
        logic        depth;
        logic [3:0]  sub;
        logic [63:0] rows_lo;
        logic [63:0] rows_hi;
        logic [63:0] upper_lo;
        logic [63:0] upper_hi;
    } tile_item_t;

    typedef struct packed {
        logic [31:0] pair;
        logic        last;
    } pixel_pair_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic [7:0]  s_pal_addr = '0;
    logic [15:0] s_pal_color = '0;
    logic        s_tile_depth = 1'b0;
    logic [3:0]  s_sub_palette = '0;
    logic [63:0] s_rows_low_half = '0;
    logic [63:0] s_rows_high_half = '0;
    logic [63:0] s_upper_planes_low = '0;
    logic [63:0] s_upper_planes_high = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_pixel_pair;
    logic        m_last_pair;

    tile_item_t  items_to_send[$];
    tile_item_t  on_offer;
    pixel_pair_t pairs_due[$];
    logic [15:0] palette_copy[PAL_ENTRIES];
    int          send_gap = 0;
    int          stall_left = 0;
    bit          long_hold_done = 1'b0;
    int          pairs_seen = 0;
    int          mismatches = 0;
    int          cycle_cnt = 0;

    planar_tile_palette_decoder u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_pal_addr          (s_pal_addr),
        .s_pal_color         (s_pal_color),
        .s_tile_depth        (s_tile_depth),
        .s_sub_palette       (s_sub_palette),
        .s_rows_low_half     (s_rows_low_half),
        .s_rows_high_half    (s_rows_high_half),
        .s_upper_planes_low  (s_upper_planes_low),
        .s_upper_planes_high (s_upper_planes_high),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_pixel_pair        (m_pixel_pair),
        .m_last_pair         (m_last_pair)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly short gaps, a few long ones, none during calm stretches
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 15);
        if (cycle_cnt[8:7] == 2'b11 || r < 8) begin
            return 0;
        end
        if (r < 14) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 60);
    endfunction

    function automatic tile_item_t random_item(input logic action);
        tile_item_t it;
        it.action    = action;
        it.pal_addr  = 8'($urandom);
        it.pal_color = 16'($urandom);
        it.depth     = 1'($urandom);
        it.sub       = 4'($urandom);
        it.rows_lo   = rand64();
        it.rows_hi   = rand64();
        it.upper_lo  = rand64();
        it.upper_hi  = rand64();
        return it;
    endfunction

    function automatic tile_item_t pal_write(input logic [7:0] addr, input logic [15:0] color);
        tile_item_t it;
        it = random_item(ACT_PAL_WRITE);
        it.pal_addr  = addr;
        it.pal_color = color;
        return it;
    endfunction

    function automatic tile_item_t tile(input logic depth, input logic [3:0] sub,
                                        input logic [63:0] rows, input logic [63:0] upper);
        tile_item_t it;
        it = random_item(ACT_TILE);
        it.depth    = depth;
        it.sub      = sub;
        it.rows_lo  = rows;
        it.rows_hi  = rows;
        it.upper_lo = upper;
        it.upper_hi = upper;
        return it;
    endfunction

    function automatic logic [15:0] pixel_color(input tile_item_t it, input int row,
                                                input int col);
        logic [63:0] rsrc;
        logic [63:0] usrc;
        logic [15:0] w;
        logic [15:0] u;
        logic [3:0]  idx;
        int          b;
        int          addr;
        b    = 7 - col;
        rsrc = (row < 4) ? it.rows_lo : it.rows_hi;
        usrc = (row < 4) ? it.upper_lo : it.upper_hi;
        w    = rsrc[16 * (row % 4) +: 16];
        u    = usrc[16 * (row % 4) +: 16];
        idx  = {1'b0, 1'b0, w[b + 8], w[b]};
        if (it.depth == DEPTH_4BPP) begin
            idx[2] = u[b];
            idx[3] = u[b + 8];
        end
        if (idx == 4'd0) begin
            return 16'h0000;
        end
        addr = ((it.depth == DEPTH_4BPP) ? int'(it.sub) * 16 : int'(it.sub) * 4) + int'(idx);
        if (addr >= PAL_ENTRIES) begin
            return 16'h0000;
        end
        return palette_copy[addr];
    endfunction

    // apply one accepted item: update the palette or queue the 32 pixel pairs of a tile
    task automatic apply_item(input tile_item_t it);
        int          n;
        int          hi_row;
        int          row;
        int          col;
        pixel_pair_t pp;
        n = 0;
        if (it.action == ACT_PAL_WRITE) begin
            if (int'(it.pal_addr) < PAL_ENTRIES) begin
                palette_copy[it.pal_addr] = it.pal_color;
            end
        end else begin
            for (int half = 1; half >= 0; half--) begin
                for (int grp = 0; grp < 2; grp++) begin
                    for (int rp = 0; rp < 2; rp++) begin
                        hi_row = half * 4 + ((rp == 0) ? 3 : 1);
                        for (int q = 0; q < 2; q++) begin
                            for (int k = 0; k < 2; k++) begin
                                row     = hi_row - k;
                                col     = grp * 4 + q * 2;
                                pp.pair = {pixel_color(it, row, col + 1),
                                           pixel_color(it, row, col)};
                                pp.last = (n == TILE_PAIRS - 1);
                                pairs_due.push_back(pp);
                                n++;
                            end
                        end
                    end
                end
            end
        end
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at %0t: %s expected %h actual %h", $realtime, what, want, got);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_item(on_offer);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (items_to_send.size() > 0) begin
                    on_offer            <= items_to_send[0];
                    s_action            <= items_to_send[0].action;
                    s_pal_addr          <= items_to_send[0].pal_addr;
                    s_pal_color         <= items_to_send[0].pal_color;
                    s_tile_depth        <= items_to_send[0].depth;
                    s_sub_palette       <= items_to_send[0].sub;
                    s_rows_low_half     <= items_to_send[0].rows_lo;
                    s_rows_high_half    <= items_to_send[0].rows_hi;
                    s_upper_planes_low  <= items_to_send[0].upper_lo;
                    s_upper_planes_high <= items_to_send[0].upper_hi;
                    void'(items_to_send.pop_front());
                    s_valid  <= 1'b1;
                    send_gap <= idle_cycles();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver readiness, with one long hold so the block backs up
    always @(posedge aclk) begin : rx_ready
        int n;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (!long_hold_done && pairs_seen >= 40) begin
            m_ready        <= 1'b0;
            stall_left     <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            n = idle_cycles();
            m_ready    <= (n == 0);
            stall_left <= (n > 0) ? n - 1 : 0;
        end
    end

    // monitor
    always @(posedge aclk) begin : monitor
        pixel_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            pairs_seen <= pairs_seen + 1;
            if (pairs_due.size() == 0) begin
                note_mismatch("unexpected pixel_pair", 32'h0, m_pixel_pair);
            end else begin
                want = pairs_due.pop_front();
                if (m_pixel_pair !== want.pair) begin
                    note_mismatch("pixel_pair", want.pair, m_pixel_pair);
                end
                if (m_last_pair !== want.last) begin
                    note_mismatch("last_pair", 32'(want.last), 32'(m_last_pair));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("planar_tile_palette_decoder verification failed");
            $finish;
        end
    end

    initial begin
        foreach (palette_copy[i]) begin
            palette_copy[i] = 16'h0000;
        end

        // directed: palette extremes, index zero, depths, sub-palette extremes, ignored planes
        items_to_send.push_back(tile(1'b1, 4'd15, '1, '1));
        items_to_send.push_back(pal_write(8'd0, 16'hFFFF));
        items_to_send.push_back(pal_write(8'd1, 16'h0001));
        items_to_send.push_back(pal_write(8'd2, 16'h8000));
        items_to_send.push_back(pal_write(8'd3, 16'h7FFF));
        items_to_send.push_back(pal_write(8'd12, 16'hA5A5));
        items_to_send.push_back(pal_write(8'd61, 16'h1234));
        items_to_send.push_back(pal_write(8'd63, 16'h00FF));
        items_to_send.push_back(pal_write(8'd255, 16'hFFFF));
        items_to_send.push_back(pal_write(8'd254, 16'h0000));
        items_to_send.push_back(pal_write(8'd240, 16'hDEAD));
        items_to_send.push_back(tile(1'b0, 4'd0, '0, '1));
        items_to_send.push_back(tile(1'b0, 4'd0, '1, '1));
        items_to_send.push_back(tile(1'b0, 4'd0, {4{16'h0FF0}}, '0));
        items_to_send.push_back(tile(1'b0, 4'd15, {4{16'h5AC3}}, rand64()));
        items_to_send.push_back(tile(1'b1, 4'd0, '0, '1));
        items_to_send.push_back(tile(1'b1, 4'd15, '1, '1));
        items_to_send.push_back(tile(1'b1, 4'd15, {4{16'h8001}}, {4{16'h0180}}));
        items_to_send.push_back(tile(1'b1, 4'd0, '0, '0));
        items_to_send.push_back(random_item(ACT_TILE));
        items_to_send.push_back(pal_write(8'd255, 16'h0000));
        items_to_send.push_back(tile(1'b1, 4'd15, '1, '1));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            items_to_send.push_back(random_item(($urandom_range(0, 99) < 35) ?
                                                ACT_PAL_WRITE : ACT_TILE));
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_to_send.size() > 0 || s_valid) begin
            @(posedge aclk);
        end
        while (pairs_due.size() > 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);

        if (mismatches == 0 && pairs_due.size() == 0) begin
            $display("planar_tile_palette_decoder verification clean");
        end else begin
            $display("planar_tile_palette_decoder verification failed");
        end
        $finish;
    end

endmodule
